@@ hdl/incdec_pkg.sv @@
// ----------------------------------------------------------------------------
// incdec_pkg
// Shared types, register codes and decode helpers for the increment and
// decrement instruction unit.
// ----------------------------------------------------------------------------
package incdec_pkg;

   // Register file entries kept in the word memory
   typedef enum logic [1:0] {
      ENT_BC,
      ENT_DE,
      ENT_A,
      ENT_SP
   } entry_type;

   localparam int unsigned RF_DEPTH = 4;

   // Request kinds
   typedef enum logic {
      REQ_EXEC,
      REQ_LOAD
   } req_kind_type;

   // Load selects
   localparam logic [3:0] SEL_B     = 4'd0;
   localparam logic [3:0] SEL_C     = 4'd1;
   localparam logic [3:0] SEL_D     = 4'd2;
   localparam logic [3:0] SEL_E     = 4'd3;
   localparam logic [3:0] SEL_H     = 4'd4;
   localparam logic [3:0] SEL_L     = 4'd5;
   localparam logic [3:0] SEL_FLAGS = 4'd6;
   localparam logic [3:0] SEL_A     = 4'd7;
   localparam logic [3:0] SEL_SP    = 4'd8;

   // Byte register codes in opcode bits 5:3
   localparam logic [2:0] CODE_B = 3'd0;
   localparam logic [2:0] CODE_C = 3'd1;
   localparam logic [2:0] CODE_D = 3'd2;
   localparam logic [2:0] CODE_E = 3'd3;
   localparam logic [2:0] CODE_H = 3'd4;
   localparam logic [2:0] CODE_L = 3'd5;
   localparam logic [2:0] CODE_M = 3'd6;
   localparam logic [2:0] CODE_A = 3'd7;

   // Register pair codes in opcode bits 5:4
   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_SP = 2'd3;

   // Opcode group patterns
   localparam logic [7:0] OP_BYTE_MASK  = 8'hC6;
   localparam logic [7:0] OP_BYTE_MATCH = 8'h04;
   localparam logic [7:0] OP_PAIR_MASK  = 8'hC7;
   localparam logic [7:0] OP_PAIR_MATCH = 8'h03;

   // Flag register constants
   localparam logic [7:0] FLAGS_RESET     = 8'h02;
   localparam logic [7:0] FLAGS_LOAD_MASK = 8'hD5;
   localparam logic [7:0] FLAGS_FIXED_SET = 8'h02;

   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   opcode;
      logic [7:0]   mem_data;
      logic [3:0]   reg_select;
      logic [15:0]  load_value;
   } req_fields_type;

   typedef struct packed {
      logic        status;
      logic        mem_write;
      logic [7:0]  mem_wdata;
      logic [15:0] result_value;
      logic [15:0] hl_next;
      logic [7:0]  flags_next;
      logic        rf_we;
      logic [15:0] rf_wdata;
   } exec_type;

   function automatic logic is_byte_op(input logic [7:0] op);
      return (op & OP_BYTE_MASK) == OP_BYTE_MATCH;
   endfunction

   function automatic logic is_pair_op(input logic [7:0] op);
      return (op & OP_PAIR_MASK) == OP_PAIR_MATCH;
   endfunction

   // Memory entry touched by a transaction (BC when none is touched)
   function automatic entry_type entry_of(input req_fields_type rq);
      entry_type ent;
      ent = ENT_BC;
      if (rq.kind == REQ_LOAD) begin
         case (rq.reg_select)
            SEL_D, SEL_E: ent = ENT_DE;
            SEL_A:        ent = ENT_A;
            SEL_SP:       ent = ENT_SP;
            default:      ent = ENT_BC;
         endcase
      end else if (is_byte_op(rq.opcode)) begin
         case (rq.opcode[5:3])
            CODE_D, CODE_E: ent = ENT_DE;
            CODE_A:         ent = ENT_A;
            default:        ent = ENT_BC;
         endcase
      end else if (is_pair_op(rq.opcode)) begin
         case (rq.opcode[5:4])
            PAIR_DE: ent = ENT_DE;
            PAIR_SP: ent = ENT_SP;
            default: ent = ENT_BC;
         endcase
      end
      return ent;
   endfunction

endpackage

@@ hdl/incdec_if.sv @@
// ----------------------------------------------------------------------------
// incdec_if
// Valid/ready channels for requests and responses of the instruction unit.
// ----------------------------------------------------------------------------
interface incdec_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  req_opcode;
   logic [7:0]  req_mem_data;
   logic [3:0]  req_reg_select;
   logic [15:0] req_load_value;

   modport source (
      output valid, req_type, req_opcode, req_mem_data, req_reg_select, req_load_value,
      input  ready
   );
   modport sink (
      input  valid, req_type, req_opcode, req_mem_data, req_reg_select, req_load_value,
      output ready
   );
endinterface

interface incdec_rsp_if;
   logic        valid;
   logic        ready;
   logic        rsp_status;
   logic        rsp_mem_write;
   logic [15:0] rsp_mem_addr;
   logic [7:0]  rsp_mem_wdata;
   logic [7:0]  rsp_flags_out;
   logic [15:0] rsp_result_value;

   modport source (
      output valid, rsp_status, rsp_mem_write, rsp_mem_addr, rsp_mem_wdata,
             rsp_flags_out, rsp_result_value,
      input  ready
   );
   modport sink (
      input  valid, rsp_status, rsp_mem_write, rsp_mem_addr, rsp_mem_wdata,
             rsp_flags_out, rsp_result_value,
      output ready
   );
endinterface

@@ hdl/incdec_rf.sv @@
// ----------------------------------------------------------------------------
// incdec_rf
// Word register file (BC, DE, A, SP): one write port, one registered read
// port. Entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module incdec_rf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  incdec_pkg::entry_type rd_addr,
   output logic [15:0]           rd_data,
   input  logic                  wr_en,
   input  incdec_pkg::entry_type wr_addr,
   input  logic [15:0]           wr_data
);
   import incdec_pkg::*;

   logic [15:0]         mem [RF_DEPTH];
   logic [RF_DEPTH-1:0] written_ff;
   logic [RF_DEPTH-1:0] written_in;
   logic [15:0]         rd_word_ff;
   logic                rd_written_ff;

   // Write port and registered read (read returns the old word on a collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // Track written entries so the array needs no clearing pass
   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff <= written_in;
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_word_ff : 16'h0000;

endmodule

@@ hdl/incdec_alu.sv @@
// ----------------------------------------------------------------------------
// incdec_alu
// Execute stage: decodes a transaction, adds or subtracts one on a byte or a
// pair or loads one register, builds the flag byte and the register file write-back.
// ----------------------------------------------------------------------------
module incdec_alu (
   input  incdec_pkg::req_fields_type rq,
   input  logic [15:0]                operand,
   input  logic [15:0]                hl,
   input  logic [7:0]                 flags,
   output incdec_pkg::exec_type       ex
);
   import incdec_pkg::*;

   logic [2:0]  code;
   logic        byte_dec;
   logic [7:0]  src8;
   logic [7:0]  res8;
   logic        aux_carry;
   logic [7:0]  byte_flags;
   logic [1:0]  pair;
   logic [15:0] cur16;
   logic [15:0] res16;
   logic [7:0]  load8;

   assign code     = rq.opcode[5:3];
   assign byte_dec = rq.opcode[0];
   assign pair     = rq.opcode[5:4];
   assign load8    = rq.load_value[7:0];

   // Select the byte operand
   always_comb begin
      case (code)
         CODE_B, CODE_D: src8 = operand[15:8];
         CODE_H:         src8 = hl[15:8];
         CODE_L:         src8 = hl[7:0];
         CODE_M:         src8 = rq.mem_data;
         default:        src8 = operand[7:0];
      endcase
   end

   // Byte increment or decrement with nibble carry or borrow
   assign res8       = byte_dec ? (src8 - 8'd1) : (src8 + 8'd1);
   assign aux_carry  = byte_dec ? (src8[3:0] == 4'h0) : (src8[3:0] == 4'hF);
   assign byte_flags = {res8[7], (res8 == 8'h00), 1'b0, aux_carry, 1'b0, ~^res8, 1'b1,
                        flags[0]};

   // Pair increment or decrement, wrapping at 16 bits
   assign cur16 = (pair == PAIR_HL) ? hl : operand;
   assign res16 = rq.opcode[3] ? (cur16 - 16'd1) : (cur16 + 16'd1);

   // Build write-back and response
   always_comb begin
      ex            = '0;
      ex.hl_next    = hl;
      ex.flags_next = flags;
      ex.rf_wdata   = operand;
      if (rq.kind == REQ_LOAD) begin
         ex.result_value = {8'h00, load8};
         case (rq.reg_select)
            SEL_B, SEL_D: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = {load8, operand[7:0]};
            end
            SEL_C, SEL_E: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = {operand[15:8], load8};
            end
            SEL_H: ex.hl_next = {load8, hl[7:0]};
            SEL_L: ex.hl_next = {hl[15:8], load8};
            SEL_FLAGS: begin
               ex.flags_next   = (load8 & FLAGS_LOAD_MASK) | FLAGS_FIXED_SET;
               ex.result_value = {8'h00, (load8 & FLAGS_LOAD_MASK) | FLAGS_FIXED_SET};
            end
            SEL_A: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = {8'h00, load8};
            end
            SEL_SP: begin
               ex.rf_we        = 1'b1;
               ex.rf_wdata     = rq.load_value;
               ex.result_value = rq.load_value;
            end
            default: begin
               ex.status       = 1'b1;
               ex.result_value = 16'h0000;
            end
         endcase
      end else if (is_byte_op(rq.opcode)) begin
         ex.flags_next   = byte_flags;
         ex.result_value = {8'h00, res8};
         case (code)
            CODE_B, CODE_D: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = {res8, operand[7:0]};
            end
            CODE_C, CODE_E: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = {operand[15:8], res8};
            end
            CODE_H: ex.hl_next = {res8, hl[7:0]};
            CODE_L: ex.hl_next = {hl[15:8], res8};
            CODE_M: begin
               ex.mem_write = 1'b1;
               ex.mem_wdata = res8;
            end
            default: begin
               ex.rf_we    = 1'b1;
               ex.rf_wdata = {8'h00, res8};
            end
         endcase
      end else if (is_pair_op(rq.opcode)) begin
         ex.result_value = res16;
         if (pair == PAIR_HL) begin
            ex.hl_next = res16;
         end else begin
            ex.rf_we    = 1'b1;
            ex.rf_wdata = res16;
         end
      end else begin
         ex.status = 1'b1;
      end
   end

endmodule

@@ hdl/incdec_instruction_unit_core.sv @@
// ----------------------------------------------------------------------------
// incdec_instruction_unit_core
// Increment/decrement instruction unit with register load, on a kept
// register file.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one transaction: execute an opcode of the INR/DCR/INX/DCX
//   group, or load one register. rsp_bus returns exactly one response per
//   request, in order: status, memory write for INR M / DCR M, HL, flags and
//   the new destination value.
//   An accepted request is held in the execute stage, then in the response
//   register that drives rsp_bus. Throughput: one transaction per cycle while
//   rsp_bus is not stalled. The memory read port sets this: the register file
//   word is read at acceptance, returned registered, modified and written back;
//   a write from the transaction just before is forwarded to the next one.
//   Reset (synchronous, active high): B, C, D, E, H, L, A and SP read as zero,
//   the flag register holds 02h, both pipeline stages empty, and req_bus.ready
//   stays low while reset is high.
//   Stall: a held response keeps its value; the execute stage behind it still
//   holds one more transaction, then req_bus.ready drops until rsp_bus moves.
// ----------------------------------------------------------------------------
module incdec_instruction_unit_core (
   input logic          clock,
   input logic          reset,
   incdec_req_if.sink   req_bus,
   incdec_rsp_if.source rsp_bus
);
   import incdec_pkg::*;

   req_fields_type req_fields;
   logic           req_ready;
   logic           req_accept;
   logic           s1_fire;

   logic           s1_valid_ff;
   logic           s1_valid_in;
   req_fields_type s1_req_ff;
   entry_type      s1_entry_ff;

   logic [15:0]    rd_data;
   logic [15:0]    operand;
   exec_type       ex;

   logic [15:0]    hl_ff;
   logic [7:0]     flags_ff;

   logic           fwd_valid_ff;
   entry_type      fwd_addr_ff;
   logic [15:0]    fwd_data_ff;

   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           rsp_status_ff;
   logic           rsp_mem_write_ff;
   logic [15:0]    rsp_mem_addr_ff;
   logic [7:0]     rsp_mem_wdata_ff;
   logic [7:0]     rsp_flags_out_ff;
   logic [15:0]    rsp_result_value_ff;

   // Gather the request payload
   assign req_fields.kind       = req_kind_type'(req_bus.req_type);
   assign req_fields.opcode     = req_bus.req_opcode;
   assign req_fields.mem_data   = req_bus.req_mem_data;
   assign req_fields.reg_select = req_bus.req_reg_select;
   assign req_fields.load_value = req_bus.req_load_value;

   // Handshake: advance the execute stage when the output register frees up
   assign s1_fire       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_ready     = !reset && (!s1_valid_ff || s1_fire);
   assign req_accept    = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   // Register file: read on accept, write back on execute
   incdec_rf u_rf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (entry_of(req_fields)),
      .rd_data (rd_data),
      .wr_en   (s1_fire && ex.rf_we),
      .wr_addr (s1_entry_ff),
      .wr_data (ex.rf_wdata)
   );

   // Forward the last write when it hit the entry being executed
   assign operand = (fwd_valid_ff && (fwd_addr_ff == s1_entry_ff)) ? fwd_data_ff : rd_data;

   incdec_alu u_alu (
      .rq      (s1_req_ff),
      .operand (operand),
      .hl      (hl_ff),
      .flags   (flags_ff),
      .ex      (ex)
   );

   // Stage valid flags
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         hl_ff        <= 16'h0000;
         flags_ff     <= FLAGS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            fwd_valid_ff <= ex.rf_we;
            hl_ff        <= ex.hl_next;
            flags_ff     <= ex.flags_next;
         end
      end
   end

   // Payload registers: capture request, forwarding data and response
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff   <= req_fields;
         s1_entry_ff <= entry_of(req_fields);
      end
      if (s1_fire) begin
         fwd_addr_ff         <= s1_entry_ff;
         fwd_data_ff         <= ex.rf_wdata;
         rsp_status_ff       <= ex.status;
         rsp_mem_write_ff    <= ex.mem_write;
         rsp_mem_addr_ff     <= ex.hl_next;
         rsp_mem_wdata_ff    <= ex.mem_wdata;
         rsp_flags_out_ff    <= ex.flags_next;
         rsp_result_value_ff <= ex.result_value;
      end
   end

   // Drive the response channel
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.rsp_status       = rsp_status_ff;
   assign rsp_bus.rsp_mem_write    = rsp_mem_write_ff;
   assign rsp_bus.rsp_mem_addr     = rsp_mem_addr_ff;
   assign rsp_bus.rsp_mem_wdata    = rsp_mem_wdata_ff;
   assign rsp_bus.rsp_flags_out    = rsp_flags_out_ff;
   assign rsp_bus.rsp_result_value = rsp_result_value_ff;

`ifndef SYNTHESIS
   // Flag register always keeps bit 1 set and bits 3 and 5 clear
   a_flags_fixed: assert property (@(posedge clock) disable iff (reset)
      (flags_ff[1] == 1'b1) && (flags_ff[3] == 1'b0) && (flags_ff[5] == 1'b0))
      else $error("flag register lost its fixed bits");

   // A full execute stage behind a stalled response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request accepted while the pipeline is full and stalled");

   // A pending memory write targets the current HL pair
   a_mem_addr_hl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mem_write_ff) |-> (rsp_mem_addr_ff == hl_ff))
      else $error("memory write address differs from HL");

   // A rejected transaction changes nothing it reports
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |->
         (!rsp_mem_write_ff && (rsp_result_value_ff == 16'h0000)))
      else $error("rejected transaction reports a result");
`endif

endmodule
